// File: rtl/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg
// Shared types and constants of the linear classifier argmax unit.
// ----------------------------------------------------------------------------
package lca_pkg;

  localparam int NUM_CLASSES_DEF  = 10;
  localparam int NUM_FEATURES_DEF = 784;
  localparam int WEIGHT_W         = 32;
  localparam int FEAT_W           = 16;
  localparam int PROD_W           = WEIGHT_W + FEAT_W;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_FEAT = 1'b1
  } lca_cmd_e;

  typedef struct packed {
    logic                       opcode;
    logic [3:0]                 class_index;
    logic [9:0]                 weight_index;
    logic signed [WEIGHT_W-1:0] weight_value;
    logic signed [FEAT_W-1:0]   feature_value;
    logic                       last_feature;
    logic [3:0]                 sample_label;
  } lca_in_t;

  typedef struct packed {
    logic [3:0]  predicted_class;
    logic        is_correct;
    logic [31:0] correct_count;
    logic [31:0] total_count;
  } lca_out_t;

  typedef struct packed {
    lca_cmd_e                   kind;
    logic [3:0]                 cls;
    logic [9:0]                 widx;
    logic signed [WEIGHT_W-1:0] wval;
    logic signed [FEAT_W-1:0]   feat;
    logic                       last;
    logic [3:0]                 label;
  } lca_cmd_t;

endpackage

// File: rtl/lca_ram.sv
// ----------------------------------------------------------------------------
// lca_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lca_front.sv
// ----------------------------------------------------------------------------
// lca_front
// Input side: accepts items, drops out-of-range weight loads and queues
// commands for the execution side in a two-entry queue.
// ----------------------------------------------------------------------------
module lca_front #(
  parameter int NUM_CLASSES  = lca_pkg::NUM_CLASSES_DEF,
  parameter int NUM_FEATURES = lca_pkg::NUM_FEATURES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lca_pkg::lca_in_t  in_data_i,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i,
  output lca_pkg::lca_cmd_t cmd_o
);

  import lca_pkg::*;

  lca_cmd_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       keep, push, pop;
  lca_cmd_t   cmd_new;

  always_comb begin
    cmd_new.kind  = lca_cmd_e'(in_data_i.opcode);
    cmd_new.cls   = in_data_i.class_index;
    cmd_new.widx  = in_data_i.weight_index;
    cmd_new.wval  = in_data_i.weight_value;
    cmd_new.feat  = in_data_i.feature_value;
    cmd_new.last  = in_data_i.last_feature;
    cmd_new.label = in_data_i.sample_label;
  end

  assign keep = (cmd_new.kind == CMD_FEAT) ||
                ((32'(in_data_i.class_index) < 32'(NUM_CLASSES)) &&
                 (32'(in_data_i.weight_index) <= 32'(NUM_FEATURES)));

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// File: rtl/lca_back.sv
// ----------------------------------------------------------------------------
// lca_back
// Execution side: weight table writes, per-class multiply-accumulate passes,
// running argmax, tallies and the output register.
// ----------------------------------------------------------------------------
module lca_back #(
  parameter int NUM_CLASSES  = lca_pkg::NUM_CLASSES_DEF,
  parameter int NUM_FEATURES = lca_pkg::NUM_FEATURES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  lca_pkg::lca_cmd_t cmd_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lca_pkg::lca_out_t out_data_o
);

  import lca_pkg::*;

  localparam int CW    = $clog2(NUM_CLASSES);
  localparam int IW    = $clog2(NUM_FEATURES + 1);
  localparam int AW    = CW + IW;
  localparam int WDEPTH = NUM_CLASSES * (2 ** IW);
  localparam int SW    = PROD_W + IW;
  localparam int LW    = (CW > 4) ? CW : 4;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  lca_cmd_t              cur_q;
  logic [CW-1:0]         cls_q, cls_d;
  logic [IW-1:0]         pos_q, pos_d;
  logic                  init_q, init_d;
  logic                  sat;
  logic [IW-1:0]         idx_acc;

  logic                  w_we;
  logic [AW-1:0]         w_waddr, w_raddr;
  logic [WEIGHT_W-1:0]   w_rdata;
  logic [SW-1:0]         s_rdata;
  logic                  issue;

  logic                  v1_q, init1_q;
  logic [CW-1:0]         c1_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [SW-1:0]  term_d, base_d;

  logic                  v2_q, init2_q;
  logic [CW-1:0]         c2_q;
  logic signed [SW-1:0]  term_q, base_q, sum;

  logic signed [SW-1:0]  best_q;
  logic [CW-1:0]         best_cls_q;

  logic                  out_valid_q;
  lca_out_t              out_q;
  logic [31:0]           corr_q, total_q, corr_d, total_d;
  logic                  hit, out_free, take_cmd;

  assign sat     = (pos_q == IW'(NUM_FEATURES));
  assign idx_acc = sat ? '0 : IW'(pos_q + IW'(1));

  assign take_cmd  = (state_q == ST_IDLE) && cmd_valid_i;
  assign cmd_pop_o = take_cmd;

  assign w_we    = take_cmd && (cmd_i.kind == CMD_LOAD);
  assign w_waddr = {CW'(cmd_i.cls), IW'(cmd_i.widx)};
  assign w_raddr = {cls_q, init_q ? IW'(0) : idx_acc};
  assign issue   = (state_q == ST_ISSUE);

  lca_ram #(
    .WIDTH(WEIGHT_W),
    .DEPTH(WDEPTH)
  ) u_weight_ram (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .waddr_i(w_waddr),
    .wdata_i(cmd_i.wval),
    .raddr_i(w_raddr),
    .rdata_o(w_rdata)
  );

  lca_ram #(
    .WIDTH(SW),
    .DEPTH(NUM_CLASSES)
  ) u_score_ram (
    .clk_i  (clk_i),
    .we_i   (v2_q),
    .waddr_i(c2_q),
    .wdata_i(sum),
    .raddr_i(cls_q),
    .rdata_o(s_rdata)
  );

  // stage 1: product or intercept
  assign prod = $signed(w_rdata) * cur_q.feat;

  always_comb begin
    if (init1_q) begin
      term_d = SW'($signed(w_rdata));
      base_d = '0;
    end else begin
      term_d = sat ? '0 : SW'(prod);
      base_d = $signed(s_rdata);
    end
  end

  // stage 2: accumulate
  assign sum = base_q + term_q;

  always_ff @(posedge clk_i) begin
    if (take_cmd) begin
      cur_q <= cmd_i;
    end
    c1_q    <= cls_q;
    init1_q <= init_q;
    term_q  <= term_d;
    base_q  <= base_d;
    c2_q    <= c1_q;
    init2_q <= init1_q;
    if (v2_q && !init2_q && cur_q.last &&
        ((c2_q == '0) || (sum > best_q))) begin
      best_q     <= sum;
      best_cls_q <= c2_q;
    end
    if (state_q == ST_EMIT && out_free) begin
      out_q.predicted_class <= 4'(best_cls_q);
      out_q.is_correct      <= hit;
      out_q.correct_count   <= corr_d;
      out_q.total_count     <= total_d;
    end
  end

  assign hit      = (LW'(best_cls_q) == LW'(cur_q.label));
  assign out_free = !out_valid_q || !out_stall_i;
  assign corr_d   = (hit && (corr_q != '1)) ? corr_q + 32'd1 : corr_q;
  assign total_d  = (total_q != '1) ? total_q + 32'd1 : total_q;

  always_comb begin
    state_d = state_q;
    cls_d   = cls_q;
    pos_d   = pos_q;
    init_d  = init_q;
    case (state_q)
      ST_IDLE: begin
        if (take_cmd && (cmd_i.kind == CMD_FEAT)) begin
          cls_d   = '0;
          init_d  = (pos_q == '0);
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (cls_q == CW'(NUM_CLASSES - 1)) begin
          state_d = ST_WAIT;
        end else begin
          cls_d = cls_q + CW'(1);
        end
      end
      ST_WAIT: begin
        if (!v1_q && !v2_q) begin
          if (init_q) begin
            init_d  = 1'b0;
            cls_d   = '0;
            state_d = ST_ISSUE;
          end else if (cur_q.last) begin
            pos_d   = '0;
            state_d = ST_EMIT;
          end else begin
            if (!sat) begin
              pos_d = pos_q + IW'(1);
            end
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cls_q       <= '0;
      pos_q       <= '0;
      init_q      <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      corr_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cls_q   <= cls_d;
      pos_q   <= pos_d;
      init_q  <= init_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      if (state_q == ST_EMIT && out_free) begin
        corr_q      <= corr_d;
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/linear_classifier_argmax_unit.sv
// ----------------------------------------------------------------------------
// linear_classifier_argmax_unit
// One-vs-rest linear classifier scoring with argmax and accuracy tallies.
// ----------------------------------------------------------------------------
// A weight load is written to the weight memory as the execution side takes
// it. For a feature, one shared multiply-accumulate walks the classes, one
// per cycle, through a three-stage read, multiply, add pipeline on the
// weight and score memories, and drains before the next feature. The first
// feature of a sample is preceded by an extra pass that loads the intercepts.
// A final feature then places the result in the output register from the
// emit state, and waits there while a held result occupies it. Up to two
// items are queued ahead of execution.
module linear_classifier_argmax_unit #(
  parameter int NUM_CLASSES  = lca_pkg::NUM_CLASSES_DEF,
  parameter int NUM_FEATURES = lca_pkg::NUM_FEATURES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lca_pkg::lca_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lca_pkg::lca_out_t out_data_o
);

  import lca_pkg::*;

  logic     cmd_valid, cmd_pop;
  lca_cmd_t cmd;

  lca_front #(
    .NUM_CLASSES (NUM_CLASSES),
    .NUM_FEATURES(NUM_FEATURES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd)
  );

  lca_back #(
    .NUM_CLASSES (NUM_CLASSES),
    .NUM_FEATURES(NUM_FEATURES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
